### hw/rtl/hpt_pkg.sv
// Shared types, constants and commands of the hashed page table engine.
package hpt_pkg;
  localparam int PROCS        = 4;
  localparam int BUCKETS      = 2048;
  localparam int POOL_ENTRIES = 1024;
  localparam int PID_REGS     = 4;
  localparam int SLOT_W       = $clog2(PROCS);
  localparam int BKT_W        = $clog2(BUCKETS);
  localparam int HEAD_W       = SLOT_W + BKT_W;
  localparam int ENT_W        = $clog2(POOL_ENTRIES);
  localparam int LINK_W       = ENT_W + 1;
  localparam int PAGE_W       = 52;
  localparam int PID_W        = 22;
  localparam int FRAME_W      = 10;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAN  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PROC  = 2'd1,
    ST_NOT_FND  = 2'd2,
    ST_POOL_FUL = 2'd3
  } status_t;

  localparam logic [2:0] REG_PROC_COUNT   = 3'd0;
  localparam logic [2:0] REG_BUCKET_COUNT = 3'd1;
  localparam logic [2:0] REG_PID_SLOT0    = 3'd2;

  // Control from the sequencer to the modulo unit.
  typedef struct packed {
    logic               start;
    logic [PAGE_W-1:0]  dividend;
    logic [BKT_W:0]     divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [BKT_W-1:0]   remainder;
  } mod_rsp_t;
endpackage

### hw/rtl/hpt_ram.sv
// Generic single-port RAM with registered read.
module hpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/hpt_mod.sv
// Restoring bit-serial modulo unit: one dividend bit per cycle.
module hpt_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  hpt_pkg::mod_req_t req,
  output hpt_pkg::mod_rsp_t rsp
);
  localparam int CNT_W = $clog2(hpt_pkg::PAGE_W + 1);

  logic [hpt_pkg::PAGE_W-1:0] num_r;
  logic [hpt_pkg::BKT_W:0]    den_r;
  logic [hpt_pkg::BKT_W:0]    rem_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [hpt_pkg::BKT_W+1:0]  shifted;
  logic [hpt_pkg::BKT_W+1:0]  diff;

  assign shifted = {rem_r, num_r[hpt_pkg::PAGE_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        num_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(hpt_pkg::PAGE_W);
      end else if (busy_r) begin
        num_r <= num_r << 1;
        // Remainder stays below the divisor, so it fits BKT_W+1 bits.
        rem_r <= diff[hpt_pkg::BKT_W+1] ? shifted[hpt_pkg::BKT_W:0] : diff[hpt_pkg::BKT_W:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done_r, rem_r[hpt_pkg::BKT_W-1:0]};
endmodule

### hw/rtl/hashed_page_table_engine.sv
// Top level of the hashed page table engine.
//
// Requests arrive on the in_ stream (command, process id, virtual page, frame);
// each produces exactly one response transfer on the out_ stream (status, hit,
// found frame). Registers are written on the cfg_ channel by index.
// The engine holds one request at a time: in_tready is low from acceptance
// until the response transfer completes. Lookup, insert and delete run the
// slot match, the bit-serial modulo of the 52-bit page, the head read and a
// walk of the chain to its end or to a match, where every step reads the
// single-port link and page memories; an insert and a delete then add their
// memory writes. Clean walks all 2048 buckets of the process and frees every
// entry of their chains. An unknown process is answered straight after the
// slot match. The next request is accepted at the earliest in the cycle after
// the response. After reset a clearing pass writes every bucket head to null
// and chains the free list, during which no request is accepted; config writes
// are taken at any time. A stalled receiver holds the response in the output
// register and the next request waits until the response transfer completes.
module hashed_page_table_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] command, [23:2] process_id, [75:24] virtual_page, [85:76] frame_number
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [2] hit, [12:3] found_frame
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  localparam int HW = hpt_pkg::HEAD_W;
  localparam int EW = hpt_pkg::ENT_W;
  localparam int LW = hpt_pkg::LINK_W;
  localparam int BW = hpt_pkg::BKT_W;
  localparam int SW = hpt_pkg::SLOT_W;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_MATCH, S_MOD, S_HREAD, S_HWAIT, S_EREAD, S_EWAIT, S_ESTEP,
    S_INS, S_INSNXT, S_DEL, S_LINK, S_CHEAD, S_CWAIT, S_CSTEP, S_CFREE, S_CNEXT,
    S_OUT
  } state_t;

  state_t state_r;
  logic [2:0]         proc_count_r;
  logic [11:0]        bucket_count_r;
  logic [hpt_pkg::PID_W-1:0] pid_r [hpt_pkg::PID_REGS];

  hpt_pkg::cmd_t      cmd_r;
  logic [hpt_pkg::PID_W-1:0]   pid_in_r;
  logic [hpt_pkg::PAGE_W-1:0]  page_r;
  logic [hpt_pkg::FRAME_W-1:0] frame_r;
  logic [SW-1:0]      slot_r;
  logic [HW-1:0]      hidx_r;
  logic [HW:0]        init_cnt_r;
  logic [BW:0]        bcnt_r;
  logic [LW-1:0]      e_r, prev_r, free_r;
  logic [LW-1:0]      pend_val_r;
  logic [1:0]         st_r;
  logic               hit_r;
  logic [hpt_pkg::FRAME_W-1:0] found_r;

  // Memory ports.
  logic               h_we, l_we, p_we;
  logic [HW-1:0]      h_addr;
  logic [LW-1:0]      h_wdata, h_rdata;
  logic [EW-1:0]      l_addr, p_addr;
  logic [LW-1:0]      l_wdata, l_rdata;
  logic [hpt_pkg::PAGE_W+hpt_pkg::FRAME_W-1:0] p_wdata, p_rdata;

  hpt_pkg::mod_req_t  mreq;
  hpt_pkg::mod_rsp_t  mrsp;

  hpt_ram #(.WIDTH(LW), .DEPTH(hpt_pkg::PROCS * hpt_pkg::BUCKETS)) u_heads (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
  hpt_ram #(.WIDTH(LW), .DEPTH(hpt_pkg::POOL_ENTRIES)) u_links (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));
  hpt_ram #(.WIDTH(hpt_pkg::PAGE_W + hpt_pkg::FRAME_W),
            .DEPTH(hpt_pkg::POOL_ENTRIES)) u_entries (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));
  hpt_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  // Effective bucket count: zero taken as one, clamped to the table size.
  logic [BW:0] eff_b;
  always_comb begin
    if (bucket_count_r == '0) eff_b = (BW+1)'(1);
    else if (bucket_count_r > 12'(hpt_pkg::BUCKETS)) eff_b = (BW+1)'(hpt_pkg::BUCKETS);
    else eff_b = bucket_count_r[BW:0];
  end

  // Lowest active slot whose pid matches.
  logic          slot_hit;
  logic [SW-1:0] slot_sel;
  always_comb begin
    slot_hit = 1'b0;
    slot_sel = '0;
    for (int i = hpt_pkg::PID_REGS - 1; i >= 0; i--) begin
      if (i < hpt_pkg::PROCS && 3'(i) < proc_count_r && pid_r[i] == pid_in_r) begin
        slot_hit = 1'b1;
        slot_sel = SW'(i);
      end
    end
  end

  logic in_fire, out_fire;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {3'b000, found_r, hit_r, st_r};
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_count_r   <= 3'd1;
      bucket_count_r <= 12'd1229;
      for (int i = 0; i < hpt_pkg::PID_REGS; i++) pid_r[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == hpt_pkg::REG_PROC_COUNT) proc_count_r <= cfg_data[2:0];
      else if (cfg_index == hpt_pkg::REG_BUCKET_COUNT) bucket_count_r <= cfg_data[11:0];
      else if (cfg_index >= hpt_pkg::REG_PID_SLOT0 &&
               cfg_index < hpt_pkg::REG_PID_SLOT0 + 3'(hpt_pkg::PID_REGS)) begin
        pid_r[2'(cfg_index - hpt_pkg::REG_PID_SLOT0)] <= cfg_data;
      end
    end
  end

  // Memory port and modulo request drive.
  always_comb begin
    h_we = 1'b0; h_addr = hidx_r; h_wdata = hpt_pkg::NIL;
    l_we = 1'b0; l_addr = e_r[EW-1:0]; l_wdata = free_r;
    p_we = 1'b0; p_addr = e_r[EW-1:0]; p_wdata = {frame_r, page_r};
    mreq.start = 1'b0; mreq.dividend = page_r; mreq.divisor = eff_b;
    case (state_r)
      S_INIT: begin
        h_we = 1'b1; h_addr = init_cnt_r[HW-1:0];
        if (init_cnt_r < (HW+1)'(hpt_pkg::POOL_ENTRIES)) begin
          l_we = 1'b1; l_addr = init_cnt_r[EW-1:0];
          l_wdata = LW'(init_cnt_r) + 1'b1;
        end
      end
      S_MATCH: mreq.start = slot_hit && cmd_r != hpt_pkg::CMD_CLEAN;
      S_INS: begin
        // The new entry gets the page and a null link; its old link is read
        // out in the same cycle and becomes the next free head.
        p_we = 1'b1; p_addr = free_r[EW-1:0];
        l_we = 1'b1; l_addr = free_r[EW-1:0]; l_wdata = hpt_pkg::NIL;
      end
      S_DEL: l_we = 1'b1;
      S_LINK: begin
        if (prev_r == hpt_pkg::NIL) begin
          h_we = 1'b1; h_wdata = pend_val_r;
        end else begin
          l_we = 1'b1; l_addr = prev_r[EW-1:0]; l_wdata = pend_val_r;
        end
      end
      // The freed entry's old link is read while it is pointed at the free list.
      S_CSTEP: l_we = (e_r != hpt_pkg::NIL);
      S_CNEXT: h_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      init_cnt_r <= '0;
      free_r     <= '0;
    end else begin
      case (state_r)
        S_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == (HW+1)'(hpt_pkg::PROCS * hpt_pkg::BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: if (in_fire) begin
          cmd_r    <= hpt_pkg::cmd_t'(in_tdata[1:0]);
          pid_in_r <= in_tdata[23:2];
          page_r   <= in_tdata[75:24];
          frame_r  <= in_tdata[85:76];
          st_r <= hpt_pkg::ST_OK; hit_r <= 1'b0; found_r <= '0;
          state_r <= S_MATCH;
        end
        S_MATCH: begin
          slot_r <= slot_sel;
          if (!slot_hit) begin
            st_r <= hpt_pkg::ST_NO_PROC; state_r <= S_OUT;
          end else if (cmd_r == hpt_pkg::CMD_CLEAN) begin
            bcnt_r <= '0;
            hidx_r <= {slot_sel, BW'(0)};
            state_r <= S_CHEAD;
          end else state_r <= S_MOD;
        end
        S_MOD: if (mrsp.done) begin
          hidx_r <= {slot_r, mrsp.remainder};
          prev_r <= hpt_pkg::NIL;
          state_r <= S_HREAD;
        end
        S_HREAD: state_r <= S_HWAIT;
        S_HWAIT: begin
          e_r <= h_rdata;
          state_r <= S_EREAD;
        end
        S_EREAD: begin
          if (e_r == hpt_pkg::NIL) begin
            if (cmd_r == hpt_pkg::CMD_INSERT) begin
              if (free_r == hpt_pkg::NIL) begin
                st_r <= hpt_pkg::ST_POOL_FUL; state_r <= S_OUT;
              end else state_r <= S_INS;
            end else begin
              if (cmd_r == hpt_pkg::CMD_DELETE) st_r <= hpt_pkg::ST_NOT_FND;
              state_r <= S_OUT;
            end
          end else state_r <= S_EWAIT;
        end
        S_EWAIT: state_r <= S_ESTEP;
        S_ESTEP: begin
          if (cmd_r != hpt_pkg::CMD_INSERT &&
              p_rdata[hpt_pkg::PAGE_W-1:0] == page_r) begin
            if (cmd_r == hpt_pkg::CMD_LOOKUP) begin
              hit_r <= 1'b1;
              found_r <= p_rdata[hpt_pkg::PAGE_W +: hpt_pkg::FRAME_W];
              state_r <= S_OUT;
            end else begin
              // Predecessor or head takes the link of the unlinked entry.
              pend_val_r <= l_rdata;
              state_r <= S_DEL;
            end
          end else begin
            prev_r <= e_r;
            e_r <= l_rdata;
            state_r <= S_EREAD;
          end
        end
        S_INS: state_r <= S_INSNXT;
        S_INSNXT: begin
          pend_val_r <= free_r;
          free_r <= l_rdata;
          state_r <= S_LINK;
        end
        S_DEL: begin
          free_r <= e_r;
          state_r <= S_LINK;
        end
        S_LINK: state_r <= S_OUT;
        S_CHEAD: state_r <= S_CWAIT;
        S_CWAIT: begin
          e_r <= h_rdata; state_r <= S_CSTEP;
        end
        S_CSTEP: begin
          if (e_r == hpt_pkg::NIL) state_r <= S_CNEXT;
          else begin
            free_r <= e_r;
            state_r <= S_CFREE;
          end
        end
        S_CFREE: begin
          e_r <= l_rdata;
          state_r <= S_CSTEP;
        end
        S_CNEXT: begin
          bcnt_r <= bcnt_r + 1'b1;
          hidx_r <= hidx_r + 1'b1;
          if (bcnt_r == (BW+1)'(hpt_pkg::BUCKETS - 1)) state_r <= S_OUT;
          else state_r <= S_CHEAD;
        end
        S_OUT: if (out_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### test/hashed_page_table_engine_tb.sv
// Self-checking testbench for the hashed page table engine, with its own table predictor.
`timescale 1ns / 1ps

module hashed_page_table_engine_tb;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 4000;

  typedef struct packed {
    hpt_pkg::status_t            status;
    logic                        hit;
    logic [hpt_pkg::FRAME_W-1:0] frame;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [21:0] cfg_data = '0;

  hashed_page_table_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of registers and table state.
  logic [2:0]                   r_proc_count;
  logic [11:0]                  r_bucket_count;
  logic [hpt_pkg::PID_W-1:0]    r_pid_slot [hpt_pkg::PID_REGS];
  logic [hpt_pkg::LINK_W-1:0]   t_heads [hpt_pkg::PROCS*hpt_pkg::BUCKETS];
  logic [hpt_pkg::PAGE_W-1:0]   t_page  [hpt_pkg::POOL_ENTRIES];
  logic [hpt_pkg::FRAME_W-1:0]  t_frame [hpt_pkg::POOL_ENTRIES];
  logic [hpt_pkg::LINK_W-1:0]   t_link  [hpt_pkg::POOL_ENTRIES];
  logic [hpt_pkg::LINK_W-1:0]   t_free;

  resp_t       resp_q[$];
  logic [hpt_pkg::PAGE_W-1:0] known_pages[$];
  int          err_count = 0;
  int          cycles = 0;
  bit          no_idle = 0;
  bit          hold_req = 0;
  int          hold_cnt = 0;
  int          stall_cnt = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic void table_reset();
    r_proc_count = 3'd1;
    r_bucket_count = 12'd1229;
    foreach (r_pid_slot[i]) r_pid_slot[i] = '0;
    foreach (t_heads[i]) t_heads[i] = hpt_pkg::NIL;
    for (int i = 0; i < hpt_pkg::POOL_ENTRIES; i++) begin
      t_page[i] = '0;
      t_frame[i] = '0;
      t_link[i] = hpt_pkg::LINK_W'(i + 1);
    end
    t_free = '0;
  endfunction

  function automatic void release_entry(logic [hpt_pkg::LINK_W-1:0] e);
    t_link[e[hpt_pkg::ENT_W-1:0]] = t_free;
    t_free = e;
  endfunction

  // Applies one request to the predicted table and returns the response it yields.
  function automatic resp_t apply_request(hpt_pkg::cmd_t cmd,
                                          logic [hpt_pkg::PID_W-1:0] pid,
                                          logic [hpt_pkg::PAGE_W-1:0] page,
                                          logic [hpt_pkg::FRAME_W-1:0] frame);
    resp_t r;
    int slot, n, nb, idx, steps;
    logic [hpt_pkg::LINK_W-1:0] e, prev, nx, ne;
    bit matched;
    r = '{status: hpt_pkg::ST_OK, hit: 1'b0, frame: '0};
    slot = -1;
    n = (r_proc_count > hpt_pkg::PID_REGS) ? hpt_pkg::PID_REGS : r_proc_count;
    for (int i = n - 1; i >= 0; i--)
      if (r_pid_slot[i] == pid) slot = i;
    if (slot < 0) begin
      r.status = hpt_pkg::ST_NO_PROC;
    end else if (cmd == hpt_pkg::CMD_CLEAN) begin
      for (int b = 0; b < hpt_pkg::BUCKETS; b++) begin
        e = t_heads[slot*hpt_pkg::BUCKETS + b];
        steps = 0;
        while (e < hpt_pkg::NIL && steps < hpt_pkg::POOL_ENTRIES) begin
          nx = t_link[e[hpt_pkg::ENT_W-1:0]];
          release_entry(e);
          e = nx;
          steps++;
        end
        t_heads[slot*hpt_pkg::BUCKETS + b] = hpt_pkg::NIL;
      end
    end else begin
      nb = (r_bucket_count == 0) ? 1 :
           ((r_bucket_count > hpt_pkg::BUCKETS) ? hpt_pkg::BUCKETS : r_bucket_count);
      idx = slot*hpt_pkg::BUCKETS + int'(page % nb);
      prev = hpt_pkg::NIL;
      e = t_heads[idx];
      steps = 0;
      matched = 0;
      while (e < hpt_pkg::NIL && steps < hpt_pkg::POOL_ENTRIES) begin
        if (cmd != hpt_pkg::CMD_INSERT && t_page[e[hpt_pkg::ENT_W-1:0]] == page) begin
          matched = 1;
          break;
        end
        prev = e;
        e = t_link[e[hpt_pkg::ENT_W-1:0]];
        steps++;
      end
      if (cmd == hpt_pkg::CMD_LOOKUP) begin
        if (matched) begin
          r.hit = 1'b1;
          r.frame = t_frame[e[hpt_pkg::ENT_W-1:0]];
        end
      end else if (cmd == hpt_pkg::CMD_INSERT) begin
        if (t_free >= hpt_pkg::NIL) begin
          r.status = hpt_pkg::ST_POOL_FUL;
        end else begin
          ne = t_free;
          t_free = t_link[ne[hpt_pkg::ENT_W-1:0]];
          t_page[ne[hpt_pkg::ENT_W-1:0]] = page;
          t_frame[ne[hpt_pkg::ENT_W-1:0]] = frame;
          t_link[ne[hpt_pkg::ENT_W-1:0]] = hpt_pkg::NIL;
          if (prev < hpt_pkg::NIL) t_link[prev[hpt_pkg::ENT_W-1:0]] = ne;
          else t_heads[idx] = ne;
        end
      end else begin
        if (!matched) begin
          r.status = hpt_pkg::ST_NOT_FND;
        end else begin
          nx = t_link[e[hpt_pkg::ENT_W-1:0]];
          if (prev < hpt_pkg::NIL) t_link[prev[hpt_pkg::ENT_W-1:0]] = nx;
          else t_heads[idx] = nx;
          release_entry(e);
        end
      end
    end
    return r;
  endfunction

  task automatic send_req(hpt_pkg::cmd_t cmd, logic [hpt_pkg::PID_W-1:0] pid,
                          logic [hpt_pkg::PAGE_W-1:0] page,
                          logic [hpt_pkg::FRAME_W-1:0] frame);
    int gap;
    in_tdata = {2'b00, frame, page, pid, cmd};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    resp_q.push_back(apply_request(cmd, pid, page, frame));
    if (cmd == hpt_pkg::CMD_INSERT && known_pages.size() < 64) known_pages.push_back(page);
    @(negedge clk);
    gap = rand_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] index, logic [21:0] value);
    @(negedge clk);
    cfg_index = index;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      hpt_pkg::REG_PROC_COUNT:   r_proc_count = value[2:0];
      hpt_pkg::REG_BUCKET_COUNT: r_bucket_count = value[11:0];
      default: if (index >= hpt_pkg::REG_PID_SLOT0 &&
                   index < hpt_pkg::REG_PID_SLOT0 + 3'(hpt_pkg::PID_REGS))
        r_pid_slot[2'(index - hpt_pkg::REG_PID_SLOT0)] = value;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drain();
    in_tvalid = 1'b0;
    @(negedge clk);
    while (resp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [hpt_pkg::PAGE_W-1:0] rand_page();
    return hpt_pkg::PAGE_W'({$urandom(), $urandom()});
  endfunction

  // Response receiver with random stalls and one long hold on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = LONG_HOLD;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready = 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
      stall_cnt = rand_gap();
    end
  end

  always @(posedge clk) begin
    resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (resp_q.size() == 0) begin
        $error("response transfer with no request outstanding: %h", out_tdata);
        err_count++;
      end else begin
        want = resp_q.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
          err_count++;
        end
        if (out_tdata[2] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_tdata[2]);
          err_count++;
        end
        if (out_tdata[12:3] !== want.frame) begin
          $error("found_frame: expected %0d, got %0d", want.frame, out_tdata[12:3]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    logic [hpt_pkg::PAGE_W-1:0] pmax;
    pmax = {hpt_pkg::PAGE_W{1'b1}};
    send_req(hpt_pkg::CMD_LOOKUP, '0, pmax, '0);           // miss on empty table
    send_req(hpt_pkg::CMD_INSERT, '0, pmax, 10'h3ff);
    send_req(hpt_pkg::CMD_INSERT, '0, pmax, 10'h155);      // duplicate goes behind the first
    send_req(hpt_pkg::CMD_LOOKUP, '0, pmax, 10'h2aa);
    send_req(hpt_pkg::CMD_INSERT, '0, 52'd0, 10'd0);
    send_req(hpt_pkg::CMD_INSERT, '0, 52'd1229, 10'h2aa);  // same bucket as page zero
    send_req(hpt_pkg::CMD_LOOKUP, '0, 52'd1229, '0);
    send_req(hpt_pkg::CMD_DELETE, '0, pmax, '0);
    send_req(hpt_pkg::CMD_LOOKUP, '0, pmax, '0);
    send_req(hpt_pkg::CMD_DELETE, '0, pmax, '0);
    send_req(hpt_pkg::CMD_DELETE, '0, pmax, '0);           // nothing left to delete
    send_req(hpt_pkg::CMD_LOOKUP, 22'h3fffff, 52'd0, '0);  // unknown process
    wait_drain();
    write_reg(hpt_pkg::REG_PID_SLOT0 + 3'd1, 22'h3fffff);
    write_reg(hpt_pkg::REG_PID_SLOT0 + 3'd2, '0);          // duplicate of slot zero
    write_reg(hpt_pkg::REG_PID_SLOT0 + 3'd3, 22'h2aaaaa);
    write_reg(hpt_pkg::REG_PROC_COUNT, 22'd7);             // clipped to four slots
    write_reg(hpt_pkg::REG_BUCKET_COUNT, 22'd0);           // taken as a single bucket
    // Indexes past the list are ignored.
    write_reg(hpt_pkg::REG_PID_SLOT0 + 3'(hpt_pkg::PID_REGS), 22'h155555);
    write_reg(hpt_pkg::REG_PID_SLOT0 + 3'(hpt_pkg::PID_REGS + 1), 22'h3fffff);
    send_req(hpt_pkg::CMD_INSERT, 22'h2aaaaa, 52'h5555555555555, 10'h1);
    send_req(hpt_pkg::CMD_INSERT, 22'h3fffff, 52'h0aaaaaaaaaaaa, 10'h2);
    send_req(hpt_pkg::CMD_LOOKUP, 22'h2aaaaa, 52'h5555555555555, '0);
    wait_drain();
    write_reg(hpt_pkg::REG_BUCKET_COUNT, 22'hfff);         // clipped to the table size
    send_req(hpt_pkg::CMD_LOOKUP, 22'h2aaaaa, 52'h5555555555555, '0);
    send_req(hpt_pkg::CMD_CLEAN, '0, '0, '0);              // frees chains beyond the modulus
    send_req(hpt_pkg::CMD_LOOKUP, '0, 52'd0, '0);
    wait_drain();
    write_reg(hpt_pkg::REG_PROC_COUNT, 22'd0);
    send_req(hpt_pkg::CMD_LOOKUP, '0, 52'd0, '0);
    send_req(hpt_pkg::CMD_CLEAN, '0, 52'd0, '0);
    wait_drain();
    write_reg(hpt_pkg::REG_PROC_COUNT, 22'd4);
    send_req(hpt_pkg::CMD_CLEAN, 22'h3fffff, '0, '0);
    send_req(hpt_pkg::CMD_CLEAN, 22'h2aaaaa, '0, '0);
    wait_drain();
  endtask

  task automatic test_pool_full();
    write_reg(hpt_pkg::REG_PROC_COUNT, 22'd1);
    write_reg(hpt_pkg::REG_BUCKET_COUNT, 22'd2048);
    write_reg(hpt_pkg::REG_PID_SLOT0, 22'h123456);
    while (t_free != hpt_pkg::NIL)
      send_req(hpt_pkg::CMD_INSERT, 22'h123456, rand_page(), 10'($urandom()));
    send_req(hpt_pkg::CMD_INSERT, 22'h123456, rand_page(), 10'h3ff);
    send_req(hpt_pkg::CMD_LOOKUP, 22'h123456, rand_page(), '0);
    send_req(hpt_pkg::CMD_CLEAN, 22'h123456, '0, '0);
    wait_drain();
    known_pages.delete();
  endtask

  task automatic random_phase(int n_items, int procs, int buckets, bit long_hold);
    hpt_pkg::cmd_t cmd;
    logic [hpt_pkg::PID_W-1:0] pid;
    logic [hpt_pkg::PAGE_W-1:0] page;
    int r;
    write_reg(hpt_pkg::REG_PROC_COUNT, 22'(procs));
    write_reg(hpt_pkg::REG_BUCKET_COUNT, 22'(buckets));
    for (int s = 0; s < hpt_pkg::PID_REGS; s++)
      write_reg(hpt_pkg::REG_PID_SLOT0 + 3'(s), 22'($urandom()));
    known_pages.delete();
    for (int i = 0; i < n_items; i++) begin
      if (long_hold && i == 10) hold_req = 1;
      r = $urandom_range(99);
      cmd = (r < 38) ? hpt_pkg::CMD_LOOKUP : (r < 73) ? hpt_pkg::CMD_INSERT :
            (r < 98) ? hpt_pkg::CMD_DELETE : hpt_pkg::CMD_CLEAN;
      pid = ($urandom_range(9) == 0) ? 22'($urandom()) : r_pid_slot[$urandom_range(3)];
      if (known_pages.size() != 0 && $urandom_range(99) < 70)
        page = known_pages[$urandom_range(known_pages.size() - 1)];
      else
        page = rand_page();
      send_req(cmd, pid, page, 10'($urandom()));
    end
    wait_drain();
  endtask

  initial begin
    table_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_pool_full();
    no_idle = 1;
    random_phase(60, 4, 2048, 0);
    no_idle = 0;
    random_phase(80, 4, 37, 1);
    random_phase(40, 2, 1, 0);
    random_phase(60, 3, 1229, 0);
    random_phase(40, 4, 2, 0);
    random_phase(30, 1, 4095, 0);
    repeat (100) @(posedge clk);
    if (err_count == 0 && resp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/hpt_pkg.sv
hw/rtl/hpt_ram.sv
hw/rtl/hpt_mod.sv
hw/rtl/hashed_page_table_engine.sv
test/hashed_page_table_engine_tb.sv
